[rtl/ehc_pkg.sv]
package ehc_pkg;

   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned ReqUserWidth = 2;
   localparam int unsigned RspDataWidth = 8;
   localparam int unsigned VerdictWidth = 2;
   localparam int unsigned PhaseWidth   = 4;
   localparam int unsigned MatchWidth   = 4;

   // parse phases
   localparam logic [PhaseWidth-1:0] PH_LEAD       = 4'd0;
   localparam logic [PhaseWidth-1:0] PH_NAME       = 4'd1;
   localparam logic [PhaseWidth-1:0] PH_NAME_TRAIL = 4'd2;
   localparam logic [PhaseWidth-1:0] PH_VAL_START  = 4'd3;
   localparam logic [PhaseWidth-1:0] PH_VAL_TOKEN  = 4'd4;
   localparam logic [PhaseWidth-1:0] PH_VAL_QUOTED = 4'd5;
   localparam logic [PhaseWidth-1:0] PH_VAL_ESC    = 4'd6;
   localparam logic [PhaseWidth-1:0] PH_AFTER_VAL  = 4'd7;
   localparam logic [PhaseWidth-1:0] PH_PARAM_LEAD = 4'd8;
   localparam logic [PhaseWidth-1:0] PH_PNAME      = 4'd9;

   // verdict codes
   localparam logic [VerdictWidth-1:0] VERDICT_NONE        = 2'd0;
   localparam logic [VerdictWidth-1:0] VERDICT_CONTINUE    = 2'd1;
   localparam logic [VerdictWidth-1:0] VERDICT_UNSUPPORTED = 2'd2;
   localparam logic [VerdictWidth-1:0] VERDICT_ERROR       = 2'd3;

   localparam logic [MatchWidth-1:0] MATCH_LEN = 4'd12;

   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_field;
      logic       end_of_header;
   } item_type;

   // "100-continue", one character per match position
   function automatic logic [7:0] match_char(input logic [MatchWidth-1:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = "1";
         4'd1:    ch = "0";
         4'd2:    ch = "0";
         4'd3:    ch = "-";
         4'd4:    ch = "c";
         4'd5:    ch = "o";
         4'd6:    ch = "n";
         4'd7:    ch = "t";
         4'd8:    ch = "i";
         4'd9:    ch = "n";
         4'd10:   ch = "u";
         4'd11:   ch = "e";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_ows(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09);
   endfunction

   function automatic logic is_tchar(input logic [7:0] c);
      logic ok;
      case (c) inside
         [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: ok = 1'b1;
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
         8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic is_qdtext(input logic [7:0] c);
      logic ok;
      case (c) inside
         8'h09, 8'h20, 8'h21, [8'h23:8'h5B], [8'h5D:8'h7E], [8'h80:8'hFF]: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic is_pair_byte(input logic [7:0] c);
      logic ok;
      case (c) inside
         8'h09, [8'h20:8'h7E], [8'h80:8'hFF]: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

[rtl/ehc_parser.sv]
module ehc_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_valid,
   input  ehc_pkg::item_type                 step,
   output logic                              verdict_valid,
   output logic [ehc_pkg::VerdictWidth-1:0]  verdict
);

   logic [ehc_pkg::PhaseWidth-1:0] phase_ff, phase_in;
   logic [ehc_pkg::MatchWidth-1:0] match_pos_ff, match_pos_in;
   logic name_ok_ff, name_ok_in;
   logic extras_ff, extras_in;
   logic seen_any_ff, seen_any_in;
   logic seen_unsup_ff, seen_unsup_in;
   logic seen_err_ff, seen_err_in;

   logic [7:0] c;
   logic [7:0] c_low;
   logic       do_match;
   logic       finish;
   logic       bad;

   assign c     = step.data_byte;
   assign c_low = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;

   always_comb begin
      phase_in      = phase_ff;
      match_pos_in  = match_pos_ff;
      name_ok_in    = name_ok_ff;
      extras_in     = extras_ff;
      seen_any_in   = seen_any_ff;
      seen_unsup_in = seen_unsup_ff;
      seen_err_in   = seen_err_ff;
      do_match      = 1'b0;
      finish        = 1'b0;
      bad           = 1'b0;
      verdict       = ehc_pkg::VERDICT_NONE;

      if (step_valid && step.has_byte && !seen_err_ff) begin
         unique case (phase_ff)
            ehc_pkg::PH_LEAD: begin
               if (ehc_pkg::is_ows(c) || c == ehc_pkg::CHAR_COMMA) begin
               end else if (ehc_pkg::is_tchar(c)) begin
                  phase_in = ehc_pkg::PH_NAME;
                  do_match = 1'b1;
               end else bad = 1'b1;
            end
            ehc_pkg::PH_NAME: begin
               if (ehc_pkg::is_tchar(c)) do_match = 1'b1;
               else if (c == ehc_pkg::CHAR_EQUAL) begin
                  extras_in = 1'b1;
                  phase_in  = ehc_pkg::PH_VAL_START;
               end else if (ehc_pkg::is_ows(c)) phase_in = ehc_pkg::PH_NAME_TRAIL;
               else if (c == ehc_pkg::CHAR_COMMA) finish = 1'b1;
               else bad = 1'b1;
            end
            ehc_pkg::PH_NAME_TRAIL: begin
               if (ehc_pkg::is_ows(c)) begin
               end else if (c == ehc_pkg::CHAR_COMMA) finish = 1'b1;
               else bad = 1'b1;
            end
            ehc_pkg::PH_VAL_START: begin
               if (c == ehc_pkg::CHAR_QUOTE) phase_in = ehc_pkg::PH_VAL_QUOTED;
               else if (ehc_pkg::is_tchar(c)) phase_in = ehc_pkg::PH_VAL_TOKEN;
               else bad = 1'b1;
            end
            ehc_pkg::PH_VAL_TOKEN: begin
               if (ehc_pkg::is_tchar(c)) begin
               end else if (ehc_pkg::is_ows(c)) phase_in = ehc_pkg::PH_AFTER_VAL;
               else if (c == ehc_pkg::CHAR_SEMI) phase_in = ehc_pkg::PH_PARAM_LEAD;
               else if (c == ehc_pkg::CHAR_COMMA) finish = 1'b1;
               else bad = 1'b1;
            end
            ehc_pkg::PH_VAL_QUOTED: begin
               if (c == ehc_pkg::CHAR_QUOTE) phase_in = ehc_pkg::PH_AFTER_VAL;
               else if (c == ehc_pkg::CHAR_BSLASH) phase_in = ehc_pkg::PH_VAL_ESC;
               else if (!ehc_pkg::is_qdtext(c)) bad = 1'b1;
            end
            ehc_pkg::PH_VAL_ESC: begin
               if (ehc_pkg::is_pair_byte(c)) phase_in = ehc_pkg::PH_VAL_QUOTED;
               else bad = 1'b1;
            end
            ehc_pkg::PH_AFTER_VAL: begin
               if (ehc_pkg::is_ows(c)) begin
               end else if (c == ehc_pkg::CHAR_SEMI) phase_in = ehc_pkg::PH_PARAM_LEAD;
               else if (c == ehc_pkg::CHAR_COMMA) finish = 1'b1;
               else bad = 1'b1;
            end
            ehc_pkg::PH_PARAM_LEAD: begin
               if (ehc_pkg::is_ows(c) || c == ehc_pkg::CHAR_SEMI) begin
               end else if (c == ehc_pkg::CHAR_COMMA) finish = 1'b1;
               else if (ehc_pkg::is_tchar(c)) phase_in = ehc_pkg::PH_PNAME;
               else bad = 1'b1;
            end
            ehc_pkg::PH_PNAME: begin
               if (ehc_pkg::is_tchar(c)) begin
               end else if (c == ehc_pkg::CHAR_EQUAL) phase_in = ehc_pkg::PH_VAL_START;
               else bad = 1'b1;
            end
            default: bad = 1'b1;
         endcase
      end

      if (do_match) begin
         if (name_ok_ff && match_pos_ff < ehc_pkg::MATCH_LEN &&
             c_low == ehc_pkg::match_char(match_pos_ff)) begin
            match_pos_in = match_pos_ff + 4'd1;
         end else begin
            name_ok_in = 1'b0;
         end
      end

      if (bad) seen_err_in = 1'b1;

      // field end: close an element that may end here, else it is cut short
      if (step_valid && (step.end_of_field || step.end_of_header) && !seen_err_in &&
          !finish) begin
         if (phase_in == ehc_pkg::PH_NAME || phase_in == ehc_pkg::PH_NAME_TRAIL ||
             phase_in == ehc_pkg::PH_VAL_TOKEN || phase_in == ehc_pkg::PH_AFTER_VAL ||
             phase_in == ehc_pkg::PH_PARAM_LEAD) begin
            finish = 1'b1;
         end else if (phase_in != ehc_pkg::PH_LEAD) begin
            seen_err_in = 1'b1;
         end
      end

      if (finish) begin
         seen_any_in = 1'b1;
         if (!(name_ok_in && match_pos_in == ehc_pkg::MATCH_LEN && !extras_in))
            seen_unsup_in = 1'b1;
      end

      if (finish || (step_valid && (step.end_of_field || step.end_of_header))) begin
         phase_in     = ehc_pkg::PH_LEAD;
         match_pos_in = '0;
         name_ok_in   = 1'b1;
         extras_in    = 1'b0;
      end

      if (seen_err_in) verdict = ehc_pkg::VERDICT_ERROR;
      else if (!seen_any_in) verdict = ehc_pkg::VERDICT_NONE;
      else if (seen_unsup_in) verdict = ehc_pkg::VERDICT_UNSUPPORTED;
      else verdict = ehc_pkg::VERDICT_CONTINUE;

      if (step_valid && step.end_of_header) begin
         seen_any_in   = 1'b0;
         seen_unsup_in = 1'b0;
         seen_err_in   = 1'b0;
      end
   end

   assign verdict_valid = step_valid && step.end_of_header;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ehc_pkg::PH_LEAD;
         match_pos_ff  <= '0;
         name_ok_ff    <= 1'b1;
         extras_ff     <= 1'b0;
         seen_any_ff   <= 1'b0;
         seen_unsup_ff <= 1'b0;
         seen_err_ff   <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         match_pos_ff  <= match_pos_in;
         name_ok_ff    <= name_ok_in;
         extras_ff     <= extras_in;
         seen_any_ff   <= seen_any_in;
         seen_unsup_ff <= seen_unsup_in;
         seen_err_ff   <= seen_err_in;
      end
   end

`ifndef ASSERT_OFF
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= ehc_pkg::PH_PNAME)
      else $error("parse phase out of range");

   a_match_range: assert property (@(posedge clock) disable iff (reset)
      match_pos_ff <= ehc_pkg::MATCH_LEN)
      else $error("match position past end of name");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (seen_err_ff && !(step_valid && step.end_of_header)) |=> seen_err_ff)
      else $error("syntax error dropped before header end");
`endif

endmodule

[rtl/http_expect_header_classifier_core.sv]
// Expect header classifier core.
// req channel: one word per byte of an Expect field value. tdata carries the
// byte, tuser[0] says the byte is present, tuser[1] closes the current field
// value, tlast closes the whole header (and the field it is in).
// rsp channel: one word per header, sent for the tlast word; tdata[1:0] is
// the verdict: none, continue, unsupported or syntax error.
// The verdict for a tlast word is registered: the parser works on the word in the input
// register, and the result register loads its verdict when that word leaves the input register.
// Throughput: one word per cycle, unless a tlast word waits on a stalled rsp; the parser updates
// its few state bits in a single pass between the input register and the result register.
// If rsp is stalled, byte words keep flowing; only a following tlast word
// waits in the input register until the pending verdict is taken, and while it
// waits req_tready is low.
// Reset clears both registers and the parse state; a header that was in
// progress is dropped and no verdict is sent for it.
module http_expect_header_classifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ehc_pkg::ReqDataWidth-1:0]   req_tdata,  // data_byte
   input  logic [ehc_pkg::ReqUserWidth-1:0]   req_tuser,  // has_byte, end_of_field
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ehc_pkg::RspDataWidth-1:0]   rsp_tdata   // verdict, zero fill
);

   ehc_pkg::item_type in_ff, in_in;
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic [ehc_pkg::VerdictWidth-1:0] verdict_ff, verdict_in;
   logic advance;
   logic verdict_valid;
   logic [ehc_pkg::VerdictWidth-1:0] verdict;

   assign advance = in_valid_ff && (!in_ff.end_of_header || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_in.data_byte     = req_tdata;
   assign in_in.has_byte      = req_tuser[0];
   assign in_in.end_of_field  = req_tuser[1];
   assign in_in.end_of_header = req_tlast;

   always_comb begin
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;
   end

   ehc_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_valid    (advance),
      .step          (in_ff),
      .verdict_valid (verdict_valid),
      .verdict       (verdict)
   );

   always_comb begin
      if (verdict_valid) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   assign verdict_in = verdict_valid ? verdict : verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_ff <= in_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ehc_pkg::RspDataWidth - ehc_pkg::VerdictWidth){1'b0}}, verdict_ff};

`ifndef ASSERT_OFF
   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_verdict_loaded: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && in_ff.end_of_header) |=> rsp_tvalid)
      else $error("header end advanced without a verdict");

   a_ready_only_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_ff.end_of_header && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a pending verdict");
`endif

endmodule
